### src/nfc_pkg.sv
// shared constants and types for the nearest free cell search unit
`timescale 1ns / 1ps

package nfc_pkg;

    localparam int GRID_WIDTH  = 32;
    localparam int GRID_HEIGHT = 16;

    localparam int COL_W    = $clog2(GRID_WIDTH);
    localparam int ROW_W    = $clog2(GRID_HEIGHT);
    localparam int RAD_MAX  = ((GRID_WIDTH < GRID_HEIGHT) ? GRID_WIDTH : GRID_HEIGHT) - 1;
    localparam int RAD_W    = $clog2(RAD_MAX + 1);
    localparam int CRD_W    = 10;
    localparam int DIST_W   = 2 * RAD_W + 1;
    localparam int ROW_POW  = 1 << ROW_W;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 32;

    typedef struct packed {
        logic grid_wr;
        logic start;
        logic issue;
        logic next_rad;
        logic load_out;
    } nfc_cmd_t;

    typedef struct packed {
        logic last_col;
        logic have;
        logic rad_max;
        logic out_busy;
    } nfc_sts_t;

endpackage

### src/nfc_grid.sv
// occupancy grid held column by column, one column read per cycle
`timescale 1ns / 1ps

module nfc_grid
    import nfc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   wr_en,
    input  logic [4:0]             wr_col,
    input  logic [3:0]             wr_row,
    input  logic                   wr_wall,
    input  logic [COL_W-1:0]       rd_col,
    output logic [GRID_HEIGHT-1:0] rd_data
);

    logic [GRID_HEIGHT-1:0] grid_reg [GRID_WIDTH];
    logic                   wr_ok;

    assign wr_ok = wr_en && (32'(wr_col) < 32'(GRID_WIDTH)) && (32'(wr_row) < 32'(GRID_HEIGHT));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < GRID_WIDTH; c++) begin
                for (int r = 0; r < GRID_HEIGHT; r++) begin
                    grid_reg[c][r] <= (c == 0 || c == GRID_WIDTH - 1 ||
                                       r == 0 || r == GRID_HEIGHT - 1);
                end
            end
        end else if (wr_ok) begin
            grid_reg[COL_W'(wr_col)][ROW_W'(wr_row)] <= wr_wall;
        end
    end

    // columns past the edge read as all wall
    assign rd_data = (32'(rd_col) < 32'(GRID_WIDTH)) ? grid_reg[rd_col] : '1;

endmodule

### src/nfc_dpath.sv
// search datapath: query, radius and column counters, column pick, best cell, result register
`timescale 1ns / 1ps

module nfc_dpath
    import nfc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  nfc_cmd_t           cmd,
    output nfc_sts_t           sts,
    input  logic [4:0]         cell_col,
    input  logic [3:0]         cell_row,
    input  logic               cell_wall,
    input  logic signed [15:0] query_x,
    input  logic signed [15:0] query_y,
    input  logic               m_tready,
    output logic               m_tvalid,
    output logic signed [15:0] result_x,
    output logic signed [15:0] result_y,
    output logic               found
);

    typedef struct packed {
        logic             v;
        logic [RAD_W-1:0] ady;
        logic             pos;
        logic [ROW_W-1:0] row;
    } nfc_cand_t;

    function automatic logic signed [CRD_W-1:0] q88_trunc(input logic signed [15:0] s);
        logic signed [16:0] t;
        t = $signed({s[15], s}) + (s[15] ? 17'sd255 : 17'sd0);
        return CRD_W'(t >>> 8);
    endfunction

    logic signed [15:0]      qx_reg, qy_reg;
    logic signed [CRD_W-1:0] cx_reg, cy_reg;
    logic [RAD_W-1:0]        radius_reg;
    logic signed [CRD_W-1:0] dx_reg;

    logic                    col_valid_reg;
    logic [GRID_HEIGHT-1:0]  col_bits_reg;
    logic [COL_W-1:0]        col_tx_reg;
    logic [RAD_W-1:0]        col_adx_reg;

    logic                    have_reg;
    logic [DIST_W-1:0]       best_d_reg;
    logic [COL_W-1:0]        best_x_reg;
    logic [ROW_W-1:0]        best_y_reg;

    logic                    out_valid_reg;
    logic signed [15:0]      out_x_reg, out_y_reg;
    logic                    out_found_reg;

    logic [CRD_W-1:0]        rad_ext;
    logic signed [CRD_W-1:0] tx;
    logic                    tx_in;
    logic [GRID_HEIGHT-1:0]  col_data;
    logic [CRD_W-1:0]        adx;

    nfc_cand_t               tree [ROW_W+1][ROW_POW];
    nfc_cand_t               win;
    logic [DIST_W-1:0]       cand_d;
    logic                    upd;

    nfc_grid u_grid (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (cmd.grid_wr),
        .wr_col  (cell_col),
        .wr_row  (cell_row),
        .wr_wall (cell_wall),
        .rd_col  (tx[COL_W-1:0]),
        .rd_data (col_data)
    );

    assign rad_ext = CRD_W'(radius_reg);
    assign tx      = cx_reg + dx_reg;
    assign tx_in   = !tx[CRD_W-1] && (tx < $signed(CRD_W'(GRID_WIDTH)));
    assign adx     = dx_reg[CRD_W-1] ? CRD_W'(-dx_reg) : CRD_W'(dx_reg);

    // nearest empty row of the held column, upper rows first on equal distance
    always_comb begin
        logic signed [CRD_W-1:0] dy;
        logic [CRD_W-1:0]        ady;
        for (int i = 0; i < ROW_POW; i++) begin
            dy  = $signed(CRD_W'(i)) - cy_reg;
            ady = dy[CRD_W-1] ? CRD_W'(-dy) : CRD_W'(dy);
            tree[0][i].v   = (i < GRID_HEIGHT) && !col_bits_reg[i % GRID_HEIGHT] &&
                             (ady <= rad_ext);
            tree[0][i].ady = RAD_W'(ady);
            tree[0][i].pos = !dy[CRD_W-1] && (dy != '0);
            tree[0][i].row = ROW_W'(i);
        end
        for (int l = 0; l < ROW_W; l++) begin
            for (int j = 0; j < ROW_POW; j++) begin
                if (j < (ROW_POW >> (l + 1))) begin
                    if (tree[l][2*j].v && (!tree[l][2*j+1].v ||
                        {tree[l][2*j].ady, tree[l][2*j].pos} <=
                        {tree[l][2*j+1].ady, tree[l][2*j+1].pos})) begin
                        tree[l+1][j] = tree[l][2*j];
                    end else begin
                        tree[l+1][j] = tree[l][2*j+1];
                    end
                end else begin
                    tree[l+1][j] = '0;
                end
            end
        end
    end

    assign win    = tree[ROW_W][0];
    assign cand_d = DIST_W'(col_adx_reg) * DIST_W'(col_adx_reg) +
                    DIST_W'(win.ady) * DIST_W'(win.ady);
    assign upd    = col_valid_reg && win.v && (!have_reg || cand_d < best_d_reg);

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            qx_reg     <= query_x;
            qy_reg     <= query_y;
            cx_reg     <= q88_trunc(query_x);
            cy_reg     <= q88_trunc(query_y);
            radius_reg <= RAD_W'(1);
            dx_reg     <= -$signed(CRD_W'(1));
        end else if (cmd.next_rad) begin
            radius_reg <= radius_reg + RAD_W'(1);
            dx_reg     <= $signed(-(rad_ext + CRD_W'(1)));
        end else if (cmd.issue) begin
            dx_reg <= dx_reg + $signed(CRD_W'(1));
        end
        if (cmd.issue) begin
            col_bits_reg <= tx_in ? col_data : '1;
            col_tx_reg   <= tx[COL_W-1:0];
            col_adx_reg  <= RAD_W'(adx);
        end
        if (upd) begin
            best_d_reg <= cand_d;
            best_x_reg <= col_tx_reg;
            best_y_reg <= win.row;
        end
        if (cmd.load_out) begin
            out_x_reg     <= have_reg ? 16'({best_x_reg, 8'h80}) : qx_reg;
            out_y_reg     <= have_reg ? 16'({best_y_reg, 8'h80}) : qy_reg;
            out_found_reg <= have_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_valid_reg <= 1'b0;
            have_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            col_valid_reg <= cmd.issue;
            if (cmd.start) begin
                have_reg <= 1'b0;
            end else if (upd) begin
                have_reg <= 1'b1;
            end
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.last_col = (dx_reg == $signed(rad_ext));
    assign sts.have     = have_reg;
    assign sts.rad_max  = (radius_reg == RAD_W'(RAD_MAX));
    assign sts.out_busy = out_valid_reg && !m_tready;

    assign m_tvalid = out_valid_reg;
    assign result_x = out_x_reg;
    assign result_y = out_y_reg;
    assign found    = out_found_reg;

endmodule

### src/nfc_ctrl.sv
// search controller: accept, column scan per radius, stop decision, result hand-off
`timescale 1ns / 1ps

module nfc_ctrl
    import nfc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    input  logic     s_op,
    output logic     s_tready,
    output nfc_cmd_t cmd,
    input  nfc_sts_t sts
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DRAIN  = 3'd2;
    localparam logic [2:0] ST_DECIDE = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_op) begin
                        cmd.start  = 1'b1;
                        state_next = ST_SCAN;
                    end else begin
                        cmd.grid_wr = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                cmd.issue = 1'b1;
                if (sts.last_col) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (sts.have || sts.rad_max) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.next_rad = 1'b1;
                    state_next   = ST_SCAN;
                end
            end
            ST_DONE: begin
                if (!sts.out_busy) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### src/grid_nearest_free_cell_search_unit.sv
// top level of the nearest free cell search unit
`timescale 1ns / 1ps

// Holds a 32 x 16 wall/empty grid (borders walls after reset) and answers
// searches for the nearest empty cell around a Q8.8 position. A write beat
// (s_tuser = 0) sets one cell and returns nothing. A search beat
// (s_tuser = 1) returns one beat: the chosen cell centre with m_tuser set, or
// the query echoed with m_tuser clear. The grid is read one column per cycle.
// s_tready is low from a search accept until its result is loaded into the
// output register; a waiting result does not block the next beat.

module grid_nearest_free_cell_search_unit
    import nfc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // cell_col, cell_row, cell_wall, query_x, query_y
    input  logic                 s_tuser,  // op
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // result_x, result_y
    output logic                 m_tuser   // found
);

    nfc_cmd_t           cmd;
    nfc_sts_t           sts;
    logic signed [15:0] result_x, result_y;

    nfc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_op     (s_tuser),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    nfc_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .cell_col  (s_tdata[4:0]),
        .cell_row  (s_tdata[8:5]),
        .cell_wall (s_tdata[9]),
        .query_x   ($signed(s_tdata[25:10])),
        .query_y   ($signed(s_tdata[41:26])),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .result_x  (result_x),
        .result_y  (result_y),
        .found     (m_tuser)
    );

    assign m_tdata = {result_y, result_x};

endmodule

### src/nfc_checker.sv
// port level checks for the nearest free cell search unit, bound to the top level
`timescale 1ns / 1ps

module nfc_checker
    import nfc_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic                 s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tuser
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat right after reset");

    a_found_centre: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[7:0] == 8'h80 && m_tdata[23:16] == 8'h80)
        else $error("found result is not a cell centre");

    a_write_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tuser && !m_tvalid |=> !m_tvalid)
        else $error("grid write produced a result beat");

    a_search_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser |=> !s_tready)
        else $error("input taken during a search");

endmodule

bind grid_nearest_free_cell_search_unit nfc_checker u_nfc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### sim/grid_nearest_free_cell_search_unit_tb.sv
// self-checking testbench for the nearest free cell search unit, with grid and search predicted locally
`timescale 1ns / 1ps

module grid_nearest_free_cell_search_unit_tb;
    import nfc_pkg::*;

    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int DRAIN_CYCLES    = 300;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int MAX_REPORTS     = 10;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_SEARCH = 1'b1
    } grid_op_t;

    typedef struct {
        grid_op_t         op;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             wall;
        logic [15:0]      qx;
        logic [15:0]      qy;
    } grid_beat_t;

    typedef struct {
        logic [15:0] x;
        logic [15:0] y;
        logic        found;
    } free_cell_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    bit         wall_map [GRID_HEIGHT][GRID_WIDTH];
    grid_beat_t pending_beats [$];
    free_cell_t expected_cells [$];
    grid_beat_t cur_beat;
    free_cell_t want_cell;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    int         mismatches     = 0;
    int         quiet_cycles   = 0;
    int         beats_queued   = 0;

    grid_nearest_free_cell_search_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
    end

    function automatic free_cell_t find_free_cell(logic [15:0] qx, logic [15:0] qy);
        int         sx, sy, cx, cy, tx, ty, d, best_d, best_x, best_y, r, dx, dy;
        bit         have;
        free_cell_t res;
        sx = int'($signed(qx));
        sy = int'($signed(qy));
        // truncate toward zero
        cx = (sx < 0) ? -((-sx) >>> 8) : (sx >>> 8);
        cy = (sy < 0) ? -((-sy) >>> 8) : (sy >>> 8);
        have   = 1'b0;
        best_d = 0;
        best_x = 0;
        best_y = 0;
        for (r = 1; r < GRID_WIDTH && r < GRID_HEIGHT && !have; r++) begin
            for (dx = -r; dx <= r; dx++) begin
                for (dy = -r; dy <= r; dy++) begin
                    tx = cx + dx;
                    ty = cy + dy;
                    if (tx >= 0 && tx < GRID_WIDTH && ty >= 0 && ty < GRID_HEIGHT) begin
                        if (!wall_map[ty][tx]) begin
                            d = dx * dx + dy * dy;
                            if (!have || d < best_d) begin
                                have   = 1'b1;
                                best_d = d;
                                best_x = tx;
                                best_y = ty;
                            end
                        end
                    end
                end
            end
        end
        if (have) begin
            res.x     = 16'(best_x * 256 + 128);
            res.y     = 16'(best_y * 256 + 128);
            res.found = 1'b1;
        end else begin
            res.x     = qx;
            res.y     = qy;
            res.found = 1'b0;
        end
        return res;
    endfunction

    task automatic push_write(int c, int r, bit w);
        grid_beat_t b;
        b.op   = OP_WRITE;
        b.col  = c[COL_W-1:0];
        b.row  = r[ROW_W-1:0];
        b.wall = w;
        b.qx   = 16'($urandom);
        b.qy   = 16'($urandom);
        pending_beats.push_back(b);
        beats_queued++;
    endtask

    task automatic push_search(logic [15:0] qx, logic [15:0] qy);
        grid_beat_t b;
        b.op   = OP_SEARCH;
        b.col  = COL_W'($urandom);
        b.row  = ROW_W'($urandom);
        b.wall = 1'($urandom);
        b.qx   = qx;
        b.qy   = qy;
        pending_beats.push_back(b);
        beats_queued++;
    endtask

    // q8.8 position somewhere inside cell c, sign chosen so truncation lands on c
    function automatic logic [15:0] cell_query(int c);
        int f;
        f = $urandom_range(255);
        if (c < 0 || (c == 0 && $urandom_range(1) == 1))
            return 16'(c * 256 - f);
        return 16'(c * 256 + f);
    endfunction

    task automatic push_random_scenario();
        int pick, k, c0, r0, c_lo, c_hi, r_lo, r_hi, c, r, n;
        pick = $urandom_range(99);
        if (pick < 40) begin
            // wall off a square around a cell, search from its middle, maybe clear it again
            if ($urandom_range(19) == 0) begin
                k  = 7;
                c0 = ($urandom_range(1) == 1) ? 1 : GRID_WIDTH - 2;
                r0 = ($urandom_range(1) == 1) ? 1 : GRID_HEIGHT - 2;
            end else begin
                k  = $urandom_range(1, 4);
                c0 = $urandom_range(GRID_WIDTH - 1);
                r0 = $urandom_range(GRID_HEIGHT - 1);
            end
            c_lo = (c0 - k + 1 < 0) ? 0 : c0 - k + 1;
            c_hi = (c0 + k - 1 > GRID_WIDTH - 1) ? GRID_WIDTH - 1 : c0 + k - 1;
            r_lo = (r0 - k + 1 < 0) ? 0 : r0 - k + 1;
            r_hi = (r0 + k - 1 > GRID_HEIGHT - 1) ? GRID_HEIGHT - 1 : r0 + k - 1;
            for (c = c_lo; c <= c_hi; c++)
                for (r = r_lo; r <= r_hi; r++)
                    push_write(c, r, 1'b1);
            n = $urandom_range(1, 3);
            repeat (n) push_search(cell_query(c0), cell_query(r0));
            if ($urandom_range(1) == 1) begin
                for (c = c_lo; c <= c_hi; c++)
                    for (r = r_lo; r <= r_hi; r++)
                        push_write(c, r, (c == 0 || r == 0 || c == GRID_WIDTH - 1 ||
                                          r == GRID_HEIGHT - 1));
            end
        end else if (pick < 70) begin
            push_search(cell_query(int'($urandom_range(GRID_WIDTH + 3)) - 2),
                        cell_query(int'($urandom_range(GRID_HEIGHT + 3)) - 2));
        end else if (pick < 80) begin
            push_search(16'($urandom), 16'($urandom));
        end else begin
            push_write($urandom_range(GRID_WIDTH - 1), $urandom_range(GRID_HEIGHT - 1),
                       $urandom_range(9) < 7);
        end
    endtask

    task automatic wait_all_done();
        while (pending_beats.size() != 0 || s_tvalid || expected_cells.size() != 0)
            @(negedge aclk);
    endtask

    task automatic report_mismatch(string what);
        if (mismatches < MAX_REPORTS)
            $display("mismatch at %0t: %s", $time, what);
        mismatches++;
    endtask

    // input side: predict on accept, then present the next beat or idle
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (cur_beat.op == OP_WRITE)
                    wall_map[cur_beat.row][cur_beat.col] = cur_beat.wall;
                else
                    expected_cells.push_back(find_free_cell(cur_beat.qx, cur_beat.qy));
            end
            if (!s_tvalid || s_tready) begin
                if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_beat = pending_beats.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= S_TDATA_W'({cur_beat.qy, cur_beat.qx, cur_beat.wall,
                                            cur_beat.row, cur_beat.col});
                    s_tuser  <= cur_beat.op;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result side
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_cells.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat x=%h y=%h found=%b",
                                              m_tdata[15:0], m_tdata[31:16], m_tuser));
                end else begin
                    want_cell = expected_cells.pop_front();
                    if (m_tdata[15:0] !== want_cell.x || m_tdata[31:16] !== want_cell.y ||
                        m_tuser !== want_cell.found)
                        report_mismatch($sformatf(
                            "expected x=%h y=%h found=%b, got x=%h y=%h found=%b",
                            want_cell.x, want_cell.y, want_cell.found,
                            m_tdata[15:0], m_tdata[31:16], m_tuser));
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("grid_nearest_free_cell_search_unit_tb: FAIL");
                $finish;
            end
        end
    end

    initial begin
        int target;
        for (int r = 0; r < GRID_HEIGHT; r++)
            for (int c = 0; c < GRID_WIDTH; c++)
                wall_map[r][c] = (r == 0 || c == 0 || r == GRID_HEIGHT - 1 ||
                                  c == GRID_WIDTH - 1);

        // directed: corners, negative and out-of-grid starts, ties, nothing found
        push_search(16'h0000, 16'h0000);
        push_search(16'h0580, 16'h0580);
        push_search(16'hFF80, 16'h0300);
        push_search(16'hFF00, 16'h0300);
        push_search(16'h0000, 16'hFFFF);
        push_search(16'h7FFF, 16'h7FFF);
        push_search(16'h8000, 16'h8000);
        push_search(16'hF000, 16'h0800);
        push_write(0, 0, 1'b0);
        push_search(16'h0040, 16'h00C0);
        push_write(GRID_WIDTH - 1, GRID_HEIGHT - 1, 1'b0);
        push_search(16'h1FFF, 16'h0FFF);
        push_write(0, 0, 1'b1);
        push_write(GRID_WIDTH - 1, GRID_HEIGHT - 1, 1'b1);
        push_write(10, 8, 1'b1);
        push_search(16'h0A4C, 16'h08B3);
        push_write(10, 8, 1'b0);
        wait_all_done();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 86;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 86;
                end
                default: begin
                    send_idle_pct  = 28;
                    recv_stall_pct = 28;
                end
            endcase
            target = beats_queued + ITEMS_PER_PHASE;
            while (beats_queued < target)
                push_random_scenario();
            wait_all_done();
        end

        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatches == 0 && expected_cells.size() == 0)
            $display("grid_nearest_free_cell_search_unit_tb: PASS");
        else
            $display("grid_nearest_free_cell_search_unit_tb: FAIL");
        $finish;
    end

endmodule

### grid_nearest_free_cell_search_unit.f
src/nfc_pkg.sv
src/nfc_grid.sv
src/nfc_dpath.sv
src/nfc_ctrl.sv
src/grid_nearest_free_cell_search_unit.sv
src/nfc_checker.sv
sim/grid_nearest_free_cell_search_unit_tb.sv
